// ===== design/ssrq_pkg.sv =====
package ssrq_pkg;

   // default sizing
   localparam int DEPTH_DEFAULT        = 1024;
   localparam int RECORD_WIDTH_DEFAULT = 32;

   // fixed field widths
   localparam int TAG_W    = 32;
   localparam int POS_W    = 32;
   localparam int RECORD_W = 32;
   localparam int COUNT_W  = 32;

   // operation codes carried in req_tuser
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // strobes from the engine to one slot ram
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

endpackage

// ===== design/ssrq_ram.sv =====
module ssrq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  ssrq_pkg::ram_ctl_type    ctl,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import ssrq_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ssrq_engine.sv =====
module ssrq_engine #(
   parameter int DEPTH        = ssrq_pkg::DEPTH_DEFAULT,
   parameter int RECORD_WIDTH = ssrq_pkg::RECORD_WIDTH_DEFAULT,
   parameter int SLOT_W       = $clog2(DEPTH),
   parameter int OCC_W        = $clog2(DEPTH + 1),
   parameter int STORE_W      = (RECORD_WIDTH < 32) ? RECORD_WIDTH : 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [ssrq_pkg::RECORD_W-1:0] req_record,
   // result side
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [ssrq_pkg::RECORD_W-1:0] rsp_record,
   output logic [OCC_W-1:0]              rsp_occupancy,
   output logic [ssrq_pkg::COUNT_W-1:0]  rsp_drop_count,
   // tag ram
   output ssrq_pkg::ram_ctl_type         tag_ctl,
   output logic [SLOT_W-1:0]             tag_wr_addr,
   output logic [ssrq_pkg::TAG_W-1:0]    tag_wr_data,
   output logic [SLOT_W-1:0]             tag_rd_addr,
   input  logic [ssrq_pkg::TAG_W-1:0]    tag_rd_data,
   // record ram
   output ssrq_pkg::ram_ctl_type         rec_ctl,
   output logic [SLOT_W-1:0]             rec_wr_addr,
   output logic [STORE_W-1:0]            rec_wr_data,
   output logic [SLOT_W-1:0]             rec_rd_addr,
   input  logic [STORE_W-1:0]            rec_rd_data
);
   import ssrq_pkg::*;

   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(DEPTH);
   localparam logic [POS_W-1:0]   DEPTH_POS  = POS_W'(DEPTH);
   localparam logic [COUNT_W-1:0] DROP_MAX   = '1;

   state_type state_ff, state_in;

   // positions, slot pointers and counters
   logic [POS_W-1:0]    tail_ff, tail_in, head_ff, head_in;
   logic [SLOT_W-1:0]   tail_slot_ff, tail_slot_in, head_slot_ff, head_slot_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0]  drop_ff, drop_in;
   logic [POS_W-1:0]    occ_ff, occ_in;

   // captured item
   logic                func_ff;
   logic [RECORD_W-1:0] record_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                acc_ff, acc_in;
   logic [RECORD_W-1:0] rout_ff, rout_in;
   logic [OCC_W-1:0]    occ_out_ff, occ_out_in;
   logic [COUNT_W-1:0]  drop_out_ff, drop_out_in;

   logic [SLOT_W-1:0]   op_slot;
   logic [TAG_W-1:0]    tag_now;
   logic                tag_written;
   logic                hit;
   logic                done;
   logic [POS_W-1:0]    tail_inc, head_inc;

   // next slot pointer: follows position mod depth, back to zero on a position wrap
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot,
                                                   input logic [POS_W-1:0]  pos_inc);
      logic [SLOT_W-1:0] res;
      if (pos_inc == '0) begin
         res = '0;
      end else if (slot == LAST_SLOT) begin
         res = '0;
      end else begin
         res = slot + 1'b1;
      end
      return res;
   endfunction

   assign tail_inc = tail_ff + 1'b1;
   assign head_inc = head_ff + 1'b1;

   // slot of the operation and its effective tag (unwritten slots hold their index)
   assign op_slot     = (func_ff == FUNC_DEQ) ? head_slot_ff : tail_slot_ff;
   assign tag_written = FILL_W'(op_slot) < fill_ff;
   assign tag_now     = tag_written ? tag_rd_data : TAG_W'(op_slot);
   assign hit         = (func_ff == FUNC_DEQ) ? (tag_now == head_inc) : (tag_now == tail_ff);
   assign done        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // ram addressing
   assign tag_rd_addr = (req_func == FUNC_DEQ) ? head_slot_ff : tail_slot_ff;
   assign rec_rd_addr = head_slot_ff;
   assign tag_wr_addr = op_slot;
   assign tag_wr_data = (func_ff == FUNC_DEQ) ? (head_ff + DEPTH_POS) : tail_inc;
   assign rec_wr_addr = tail_slot_ff;
   assign rec_wr_data = record_ff[STORE_W-1:0];

   // sequencer and update logic
   always_comb begin
      state_in     = state_ff;
      tail_in      = tail_ff;
      head_in      = head_ff;
      tail_slot_in = tail_slot_ff;
      head_slot_in = head_slot_ff;
      fill_in      = fill_ff;
      drop_in      = drop_ff;
      occ_in       = occ_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      acc_in       = acc_ff;
      rout_in      = rout_ff;
      occ_out_in   = occ_out_ff;
      drop_out_in  = drop_out_ff;
      req_ready    = 1'b0;
      tag_ctl      = '0;
      rec_ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               tag_ctl.rd_en = 1'b1;
               rec_ctl.rd_en = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (done) begin
               state_in = ST_IDLE;
               rout_in  = '0;
               if (func_ff == FUNC_ENQ) begin
                  if (hit) begin
                     tag_ctl.wr_en = 1'b1;
                     rec_ctl.wr_en = 1'b1;
                     tail_in       = tail_inc;
                     tail_slot_in  = next_slot(tail_slot_ff, tail_inc);
                     occ_in        = occ_ff + 1'b1;
                     if (fill_ff != FILL_FULL) begin
                        fill_in = fill_ff + 1'b1;
                     end
                  end else if (drop_ff != DROP_MAX) begin
                     drop_in = drop_ff + 1'b1;
                  end
               end else begin
                  if (hit) begin
                     tag_ctl.wr_en = 1'b1;
                     head_in       = head_inc;
                     head_slot_in  = next_slot(head_slot_ff, head_inc);
                     occ_in        = occ_ff - 1'b1;
                     rout_in       = RECORD_W'(rec_rd_data);
                  end
               end
               rsp_valid_in = 1'b1;
               acc_in       = hit;
               drop_out_in  = drop_in;
               occ_out_in   = (occ_in > DEPTH_POS) ? FILL_FULL : OCC_W'(occ_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tail_ff      <= '0;
         head_ff      <= '0;
         tail_slot_ff <= '0;
         head_slot_ff <= '0;
         fill_ff      <= '0;
         drop_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         head_ff      <= head_in;
         tail_slot_ff <= tail_slot_in;
         head_slot_ff <= head_slot_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         func_ff   <= req_func;
         record_ff <= req_record;
      end
      acc_ff      <= acc_in;
      rout_ff     <= rout_in;
      occ_out_ff  <= occ_out_in;
      drop_out_ff <= drop_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = acc_ff;
   assign rsp_record     = rout_ff;
   assign rsp_occupancy  = occ_out_ff;
   assign rsp_drop_count = drop_out_ff;

endmodule

// ===== design/sequenced_slot_ring_queue_unit.sv =====
// Bounded ring queue of DEPTH slots, each with a record and a 32-bit sequence
// tag held in two single-port-read slot RAMs. An item with req_tuser = 0
// enqueues the record in req_tdata, with req_tuser = 1 it dequeues the oldest
// record. Every item gives one result: whether it succeeded, the dequeued
// record (zero otherwise), the occupancy capped at DEPTH and the saturating
// count of refused enqueues. Each item goes through a tag and record RAM read,
// then a tag compare and write-back; the result sits in an output register, so
// the next item is taken while it waits and the block only stalls when a result
// is still untaken as the next one completes. The queue is ready right after
// reset: no clearing pass, a fill count marks which tag entries are unwritten and
// read as their slot index.
module sequenced_slot_ring_queue_unit #(
   parameter int DEPTH        = ssrq_pkg::DEPTH_DEFAULT,
   parameter int RECORD_WIDTH = ssrq_pkg::RECORD_WIDTH_DEFAULT,
   parameter int OCC_W        = $clog2(DEPTH + 1),
   parameter int RSP_W        = ((2 * ssrq_pkg::RECORD_W + OCC_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ssrq_pkg::RECORD_W-1:0] req_tdata,  // record_in
   input  logic [0:0]                    req_tuser,  // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,  // record_out, occupancy, drop_count
   output logic [0:0]                    rsp_tuser   // accepted
);
   import ssrq_pkg::*;

   localparam int SLOT_W  = $clog2(DEPTH);
   localparam int STORE_W = (RECORD_WIDTH < 32) ? RECORD_WIDTH : 32;
   localparam int PAD_W   = RSP_W - (RECORD_W + OCC_W + COUNT_W);

   ram_ctl_type          tag_ctl, rec_ctl;
   logic [SLOT_W-1:0]    tag_wr_addr, tag_rd_addr, rec_wr_addr, rec_rd_addr;
   logic [TAG_W-1:0]     tag_wr_data, tag_rd_data;
   logic [STORE_W-1:0]   rec_wr_data, rec_rd_data;
   logic                 rsp_accepted;
   logic [RECORD_W-1:0]  rsp_record;
   logic [OCC_W-1:0]     rsp_occupancy;
   logic [COUNT_W-1:0]   rsp_drop_count;

   // sequence tags
   ssrq_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_tag_ram (
      .clock   (clock),
      .ctl     (tag_ctl),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data)
   );

   // stored records
   ssrq_ram #(.WIDTH(STORE_W), .DEPTH(DEPTH)) u_rec_ram (
      .clock   (clock),
      .ctl     (rec_ctl),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   // queue control
   ssrq_engine #(
      .DEPTH        (DEPTH),
      .RECORD_WIDTH (RECORD_WIDTH),
      .SLOT_W       (SLOT_W),
      .OCC_W        (OCC_W),
      .STORE_W      (STORE_W)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_func       (req_tuser[0]),
      .req_record     (req_tdata),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_accepted   (rsp_accepted),
      .rsp_record     (rsp_record),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_drop_count (rsp_drop_count),
      .tag_ctl        (tag_ctl),
      .tag_wr_addr    (tag_wr_addr),
      .tag_wr_data    (tag_wr_data),
      .tag_rd_addr    (tag_rd_addr),
      .tag_rd_data    (tag_rd_data),
      .rec_ctl        (rec_ctl),
      .rec_wr_addr    (rec_wr_addr),
      .rec_wr_data    (rec_wr_data),
      .rec_rd_addr    (rec_rd_addr),
      .rec_rd_data    (rec_rd_data)
   );

   // result packing
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_drop_count, rsp_occupancy, rsp_record};
   assign rsp_tuser = rsp_accepted;

   // slot writes happen only in the compare cycle, never while an item is taken
   assert property (@(posedge clock) disable iff (reset)
      (tag_ctl.wr_en || rec_ctl.wr_en) |-> !req_tready)
      else $error("slot write while accepting an item");

   // an accepted item is followed by its compare cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && !tag_ctl.rd_en))
      else $error("item accepted during compare cycle");

   // a refused result carries no record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_record == '0))
      else $error("record on refused result");

   // occupancy never exceeds the ring size
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_occupancy <= OCC_W'(DEPTH)))
      else $error("occupancy above depth");

endmodule
